FILE: hw/rtl/tdl_pkg.sv
// shared types, codes and sizes for the table driven lexer dfa unit
package tdl_pkg;

    localparam int TDL_NUM_STATES = 16;
    localparam int TDL_QUEUE_DEPTH = 2;
    localparam int TDL_OUT_DEPTH = 4;

    localparam logic [4:0] CODE_OP = 5'd16;
    localparam logic [4:0] CODE_SYM = 5'd17;
    localparam logic [4:0] CODE_NONE = 5'd18;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_CHAR = 2'd1,
        CMD_END = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } bk_state_t;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] table_state;
        logic [7:0] in_char;
        logic [4:0] next_code;
    } tdl_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic [4:0] token_kind;
        logic       token_end;
        logic       run_last;
    } tdl_out_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] row;
        logic [7:0] ch;
        logic [4:0] code;
    } tdl_op_t;

    typedef struct packed {
        logic [1:0] count;
        tdl_out_t   r0;
        tdl_out_t   r1;
    } tdl_push_t;

endpackage

FILE: hw/rtl/tdl_front.sv
// front end: accepts input beats, classifies them and queues them for the back end
module tdl_front
    import tdl_pkg::*;
#(
    parameter int NUM_STATES = TDL_NUM_STATES
) (
    input  logic    clk,
    input  logic    rst_n,
    input  tdl_in_t item,
    input  logic    item_valid,
    output logic    item_ready,
    input  logic    clearing,
    output tdl_op_t op,
    output logic    op_valid,
    input  logic    op_ready
);

    localparam int PW = (TDL_QUEUE_DEPTH > 1) ? $clog2(TDL_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(TDL_QUEUE_DEPTH + 1);

    tdl_op_t        entries [TDL_QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    tdl_op_t        classified;
    logic           keep;
    logic           push;
    logic           pop;

    always_comb
    begin
        classified.cmd = cmd_t'(item.command);
        classified.row = item.table_state;
        classified.ch = item.in_char;
        classified.code = item.next_code;
        if (item.next_code < 5'd16 && 32'(item.next_code) >= NUM_STATES)
        begin
            classified.code = CODE_NONE;
        end
        if (item.next_code > CODE_NONE)
        begin
            classified.code = CODE_NONE;
        end
        keep = 1'b1;
        case (cmd_t'(item.command))
            CMD_LOAD: keep = (32'(item.table_state) < NUM_STATES);
            CMD_CHAR: keep = 1'b1;
            CMD_END:  keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    assign item_ready = !clearing && (count_reg < CW'(TDL_QUEUE_DEPTH));
    assign push = item_valid && item_ready && keep;
    assign op_valid = (count_reg != '0);
    assign pop = op_valid && op_ready;
    assign op = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == TDL_QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == TDL_QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= classified;
        end
    end

endmodule

FILE: hw/rtl/tdl_back.sv
// back end: transition table, tokeniser state and result generation
module tdl_back
    import tdl_pkg::*;
#(
    parameter int NUM_STATES = TDL_NUM_STATES
) (
    input  logic      clk,
    input  logic      rst_n,
    input  tdl_op_t   op,
    input  logic      op_valid,
    output logic      op_ready,
    output logic      clearing,
    output tdl_push_t push,
    input  logic      space_ok
);

    localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int AW = SW + 8;
    localparam int DEPTH = NUM_STATES * 256;

    logic [4:0]    table_mem [DEPTH];
    logic [4:0]    rd_reg;

    bk_state_t     state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    cmd_t          cur_cmd_reg;
    logic [7:0]    cur_char_reg;
    logic [SW-1:0] cur_state_reg, cur_state_next;
    logic          held_valid_reg, held_valid_next;
    logic [7:0]    held_char_reg, held_char_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_char_reg, pend_char_next;

    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [4:0]    mem_wdata;
    logic          take;
    logic          exec;

    tdl_out_t      res [2];
    logic [1:0]    n;
    logic          is_op;
    logic          is_sym;
    logic          do_plain;
    logic [4:0]    state_kind;

    function automatic tdl_out_t mk(input logic [7:0] c, input logic [4:0] k, input logic e);
        tdl_out_t r;
        r.out_char = c;
        r.token_kind = e ? k : 5'd0;
        r.token_end = e;
        r.run_last = 1'b0;
        return r;
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (op_valid && op.cmd != CMD_LOAD)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (space_ok)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        op_ready = 1'b0;
        clearing = 1'b0;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_addr = {op.row[SW-1:0], op.ch};
        mem_wdata = op.code;
        exec = 1'b0;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                clearing = 1'b1;
                mem_we = 1'b1;
                mem_addr = clr_cnt_reg;
                mem_wdata = CODE_NONE;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            BK_IDLE:
            begin
                op_ready = 1'b1;
                mem_we = op_valid && (op.cmd == CMD_LOAD);
                mem_re = op_valid && (op.cmd == CMD_CHAR);
                // a character looks up the row of the current state
                if (op.cmd == CMD_CHAR)
                begin
                    mem_addr = {cur_state_reg, op.ch};
                end
            end
            BK_EXEC:
            begin
                exec = space_ok;
            end
            default:
            begin
                op_ready = 1'b0;
            end
        endcase
    end

    assign take = op_valid && op_ready;

    // result generation
    always_comb
    begin
        cur_state_next = cur_state_reg;
        held_valid_next = held_valid_reg;
        held_char_next = held_char_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next = pend_char_reg;
        res[0] = '0;
        res[1] = '0;
        n = 2'd0;
        is_op = (rd_reg == CODE_OP);
        is_sym = (rd_reg == CODE_SYM);
        do_plain = 1'b0;
        state_kind = 5'(cur_state_reg);
        if (exec)
        begin
            case (cur_cmd_reg)
                CMD_CHAR:
                begin
                    if (pend_valid_reg)
                    begin
                        pend_valid_next = 1'b0;
                        if (is_op)
                        begin
                            res[0] = mk(pend_char_reg, 5'd0, 1'b0);
                            res[1] = mk(cur_char_reg, CODE_OP, 1'b1);
                            n = 2'd2;
                        end
                        else
                        begin
                            res[0] = mk(pend_char_reg, CODE_OP, 1'b1);
                            n = 2'd1;
                            do_plain = 1'b1;
                        end
                    end
                    else
                    begin
                        do_plain = 1'b1;
                    end
                    if (do_plain)
                    begin
                        if (is_op || is_sym)
                        begin
                            if (held_valid_reg)
                            begin
                                res[n[0]] = mk(held_char_reg, state_kind, 1'b1);
                                n = n + 2'd1;
                            end
                            held_valid_next = 1'b0;
                            if (is_op)
                            begin
                                pend_valid_next = 1'b1;
                                pend_char_next = cur_char_reg;
                            end
                            else
                            begin
                                res[n[0]] = mk(cur_char_reg, CODE_SYM, 1'b1);
                                n = n + 2'd1;
                            end
                        end
                        else
                        begin
                            if (held_valid_reg)
                            begin
                                res[n[0]] = mk(held_char_reg, 5'd0, 1'b0);
                                n = n + 2'd1;
                            end
                            held_valid_next = 1'b1;
                            held_char_next = cur_char_reg;
                            if (32'(rd_reg) < NUM_STATES)
                            begin
                                cur_state_next = rd_reg[SW-1:0];
                            end
                        end
                    end
                end
                CMD_END:
                begin
                    if (pend_valid_reg)
                    begin
                        res[0] = mk(pend_char_reg, CODE_OP, 1'b1);
                        n = 2'd1;
                    end
                    else if (held_valid_reg)
                    begin
                        res[0] = mk(held_char_reg, state_kind, 1'b1);
                        n = 2'd1;
                    end
                    pend_valid_next = 1'b0;
                    held_valid_next = 1'b0;
                    cur_state_next = '0;
                end
                default:
                begin
                    n = 2'd0;
                end
            endcase
            if (n != 2'd0)
            begin
                res[1'(n - 2'd1)].run_last = 1'b1;
            end
        end
        push.count = n;
        push.r0 = res[0];
        push.r1 = res[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_cnt_reg <= '0;
            cur_cmd_reg <= CMD_NONE;
            cur_state_reg <= '0;
            held_valid_reg <= 1'b0;
            held_char_reg <= '0;
            pend_valid_reg <= 1'b0;
            pend_char_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (take)
            begin
                cur_cmd_reg <= op.cmd;
            end
            cur_state_reg <= cur_state_next;
            held_valid_reg <= held_valid_next;
            held_char_reg <= held_char_next;
            pend_valid_reg <= pend_valid_next;
            pend_char_reg <= pend_char_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_char_reg <= op.ch;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= table_mem[mem_addr];
        end
    end

    a_two_results_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (push.r1.run_last && !push.r0.run_last))
        else $error("run_last not on the second of two results");

    a_pend_held_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_valid_reg && held_valid_reg))
        else $error("pending operator and held character both valid");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_CLEAR) |=> (state_reg != BK_CLEAR))
        else $error("table clear restarted after completion");

    a_no_take_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EXEC && !space_ok) |=> (state_reg == BK_EXEC && $stable(cur_char_reg)))
        else $error("stalled execution lost its item");

endmodule

FILE: hw/rtl/tdl_outbuf.sv
// result buffer: takes up to two results a cycle, hands out one beat a cycle while result_ready is high
module tdl_outbuf
    import tdl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tdl_push_t push,
    output logic      space_ok,
    output tdl_out_t  result,
    output logic      result_valid,
    input  logic      result_ready
);

    localparam int PW = $clog2(TDL_OUT_DEPTH);
    localparam int CW = $clog2(TDL_OUT_DEPTH + 1);

    tdl_out_t      entries [TDL_OUT_DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign space_ok = (count_reg <= CW'(TDL_OUT_DEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result = entries[head_reg];
    assign pop = result_valid && result_ready;

    always_comb
    begin
        head_next = pop ? head_reg + 1'b1 : head_reg;
        tail_next = tail_reg + PW'(push.count);
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entries[tail_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            entries[tail_reg + 1'b1] <= push.r1;
        end
    end

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> space_ok)
        else $error("results pushed without room");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CW'(TDL_OUT_DEPTH)) && (push.count != 2'd3))
        else $error("result buffer overflow");

endmodule

FILE: hw/rtl/table_driven_lexer_dfa_unit.sv
// top level of the table driven lexer dfa unit
//
// channel   direction  handshake                    payload
// item      in         item_valid / item_ready      tdl_in_t  (command, table_state, in_char, next_code)
// result    out        result_valid / result_ready  tdl_out_t (out_char, token_kind, token_end, run_last)
//
// a load beat is written in the back end's idle state; a character or end beat is taken there (a
// character also reads its current state's row) and then executes in the exec state, which takes no
// new item and holds while the result buffer lacks room; after reset the table's NUM_STATES * 256
// entries, 4096 by default, are cleared one entry a cycle, with item_ready low
// a 2-entry item queue and a 4-entry result buffer let input and output stall independently
module table_driven_lexer_dfa_unit
    import tdl_pkg::*;
#(
    parameter int NUM_STATES = TDL_NUM_STATES
) (
    input  logic     clk,
    input  logic     rst_n,
    input  tdl_in_t  item,
    input  logic     item_valid,
    output logic     item_ready,
    output tdl_out_t result,
    output logic     result_valid,
    input  logic     result_ready
);

    tdl_op_t   op;
    logic      op_valid;
    logic      op_ready;
    logic      clearing;
    tdl_push_t push;
    logic      space_ok;

    tdl_front #(
        .NUM_STATES(NUM_STATES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .clearing  (clearing),
        .op        (op),
        .op_valid  (op_valid),
        .op_ready  (op_ready)
    );

    tdl_back #(
        .NUM_STATES(NUM_STATES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .op_valid(op_valid),
        .op_ready(op_ready),
        .clearing(clearing),
        .push    (push),
        .space_ok(space_ok)
    );

    tdl_outbuf u_outbuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .space_ok    (space_ok),
        .result      (result),
        .result_valid(result_valid),
        .result_ready(result_ready)
    );

endmodule

FILE: test/tdl_checker.sv
// checker for the lexer dfa unit: tracks the token walk and compares every result beat
module tdl_checker
    import tdl_pkg::*;
#(
    parameter int NUM_STATES = TDL_NUM_STATES
) (
    input  logic     clk,
    input  logic     rst_n,
    input  tdl_in_t  item,
    input  logic     item_valid,
    input  logic     item_ready,
    input  tdl_out_t result,
    input  logic     result_valid,
    input  logic     result_ready,
    output int       error_count,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [4:0] dfa_table [NUM_STATES*256];
    logic [3:0] dfa_state;
    logic       tail_ok;
    logic [7:0] tail_char;
    logic       op_ok;
    logic [7:0] op_char;
    tdl_out_t   tokens_due [$];
    tdl_out_t   want;

    function automatic logic [4:0] next_of(logic [7:0] ch);
        return dfa_table[int'(dfa_state) * 256 + int'(ch)];
    endfunction

    function automatic void push_char(logic [7:0] ch, logic [4:0] kind, logic ends);
        tdl_out_t r;
        r.out_char = ch;
        r.token_kind = ends ? kind : 5'd0;
        r.token_end = ends;
        r.run_last = 1'b0;
        tokens_due.insert(tokens_due.size(), r);
    endfunction

    function automatic void take_char(logic [7:0] ch);
        logic [4:0] e;
        e = next_of(ch);
        if (e == CODE_OP || e == CODE_SYM) begin
            if (tail_ok) begin
                push_char(tail_char, {1'b0, dfa_state}, 1'b1);
                tail_ok = 1'b0;
            end
            if (e == CODE_OP) begin
                op_ok = 1'b1;
                op_char = ch;
            end else begin
                push_char(ch, CODE_SYM, 1'b1);
            end
        end else begin
            if (tail_ok)
                push_char(tail_char, 5'd0, 1'b0);
            tail_ok = 1'b1;
            tail_char = ch;
            if (e < NUM_STATES)
                dfa_state = e[3:0];
        end
    endfunction

    function automatic void lex_step(tdl_in_t it);
        int         n0;
        logic [4:0] code;
        n0 = tokens_due.size();
        case (it.command)
            CMD_LOAD:
            begin
                if (it.table_state < NUM_STATES) begin
                    code = it.next_code;
                    if (code < 5'd16 && code >= NUM_STATES)
                        code = CODE_NONE;
                    if (code > CODE_NONE)
                        code = CODE_NONE;
                    dfa_table[int'(it.table_state) * 256 + int'(it.in_char)] = code;
                end
            end
            CMD_CHAR:
            begin
                if (op_ok) begin
                    op_ok = 1'b0;
                    if (next_of(it.in_char) == CODE_OP) begin
                        push_char(op_char, 5'd0, 1'b0);
                        push_char(it.in_char, CODE_OP, 1'b1);
                    end else begin
                        push_char(op_char, CODE_OP, 1'b1);
                        take_char(it.in_char);
                    end
                end else begin
                    take_char(it.in_char);
                end
            end
            CMD_END:
            begin
                if (op_ok)
                    push_char(op_char, CODE_OP, 1'b1);
                else if (tail_ok)
                    push_char(tail_char, {1'b0, dfa_state}, 1'b1);
                op_ok = 1'b0;
                tail_ok = 1'b0;
                dfa_state = 4'd0;
            end
            default:
            begin
            end
        endcase
        if (tokens_due.size() > n0)
            tokens_due[tokens_due.size() - 1].run_last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            foreach (dfa_table[i])
                dfa_table[i] = CODE_NONE;
            dfa_state = 4'd0;
            tail_ok = 1'b0;
            tail_char = 8'd0;
            op_ok = 1'b0;
            op_char = 8'd0;
            tokens_due.delete();
            error_count = 0;
            pending = 0;
        end else begin
            if (item_valid && item_ready)
                lex_step(item);
            if (result_valid && result_ready) begin
                if (tokens_due.size() == 0) begin
                    $error("result beat with no character due: out_char %0d", result.out_char);
                    error_count++;
                end else begin
                    want = tokens_due.pop_front();
                    check_field("out_char", want.out_char, result.out_char);
                    check_field("token_kind", want.token_kind, result.token_kind);
                    check_field("token_end", want.token_end, result.token_end);
                    check_field("run_last", want.run_last, result.run_last);
                end
            end
            pending = tokens_due.size();
        end
    end

endmodule

FILE: test/tb_top.sv
// testbench top for the lexer dfa unit: reset, stimulus, back-pressure and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tdl_pkg::*;

    localparam int ITEM_COUNT = 850;
    localparam int QUIET_FROM = 760;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 200000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    tdl_in_t  item = '0;
    logic     item_valid = 1'b0;
    logic     item_ready;
    tdl_out_t result;
    logic     result_valid;
    logic     result_ready = 1'b0;
    int       error_count;
    int       pending;
    int       cycles = 0;
    int       sent = 0;
    int       hold_left = 0;
    bit       quiet = 1'b0;
    bit       hold_go = 1'b0;
    bit       hold_done = 1'b0;

    table_driven_lexer_dfa_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    tdl_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .error_count  (error_count),
        .pending      (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: short random stalls, one long hold-off to fill the block
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            result_ready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            result_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 6);
            result_ready <= 1'b0;
        end else begin
            result_ready <= 1'b1;
        end
    end

    function automatic tdl_in_t mk(cmd_t c, logic [3:0] row, logic [7:0] ch, logic [4:0] code);
        tdl_in_t it;
        it.command = c;
        it.table_state = row;
        it.in_char = ch;
        it.next_code = code;
        return it;
    endfunction

    task automatic send(tdl_in_t it);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        if (it.command != CMD_NONE)
            sent++;
    endtask

    logic [7:0] pool [6];

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return pool[$urandom_range(0, 5)];
    endfunction

    initial begin
        int         n;
        int         r;
        logic [4:0] code;
        logic [3:0] row;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // small language: 'a' words, '+' operator, ';' symbol, 0xff/0x00 edges
        send(mk(CMD_LOAD, 4'd0, 8'h61, 5'd1));
        send(mk(CMD_LOAD, 4'd1, 8'h61, 5'd1));
        send(mk(CMD_LOAD, 4'd1, 8'h2b, CODE_OP));
        send(mk(CMD_LOAD, 4'd1, 8'h3b, CODE_SYM));
        send(mk(CMD_LOAD, 4'd0, 8'h2b, 5'd19));
        send(mk(CMD_LOAD, 4'd0, 8'h2b, CODE_OP));
        send(mk(CMD_LOAD, 4'd0, 8'hff, 5'd15));
        send(mk(CMD_LOAD, 4'd15, 8'h00, 5'd0));
        send(mk(CMD_LOAD, 4'd15, 8'hff, 5'd31));
        send(mk(CMD_NONE, 4'hf, 8'hff, 5'h1f));
        send(mk(CMD_CHAR, 4'd0, 8'h61, 5'd0));
        send(mk(CMD_CHAR, 4'd0, 8'h61, 5'd0));
        send(mk(CMD_CHAR, 4'd0, 8'h2b, 5'd0));
        send(mk(CMD_CHAR, 4'd0, 8'h2b, 5'd0));
        send(mk(CMD_CHAR, 4'hf, 8'h3b, 5'h1f));
        send(mk(CMD_END, 4'd0, 8'd0, 5'd0));
        send(mk(CMD_CHAR, 4'd0, 8'h2b, 5'd0));
        send(mk(CMD_CHAR, 4'd0, 8'h61, 5'd0));
        send(mk(CMD_END, 4'hf, 8'hff, 5'h1f));
        send(mk(CMD_CHAR, 4'd0, 8'h61, 5'd0));
        send(mk(CMD_CHAR, 4'd0, 8'h2b, 5'd0));
        send(mk(CMD_END, 4'd0, 8'd0, 5'd0));
        send(mk(CMD_CHAR, 4'd0, 8'hff, 5'd0));
        send(mk(CMD_CHAR, 4'd0, 8'hff, 5'd0));
        send(mk(CMD_CHAR, 4'd0, 8'h00, 5'd0));
        send(mk(CMD_END, 4'd0, 8'd0, 5'd0));

        foreach (pool[i])
            pool[i] = 8'($urandom);
        while (sent < ITEM_COUNT) begin
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    foreach (pool[i])
                        pool[i] = 8'($urandom);
                n = $urandom_range(4, 14);
                repeat (n) begin
                    r = $urandom_range(0, 19);
                    if (r < 8)
                        code = 5'($urandom_range(0, 3));
                    else if (r < 10)
                        code = 5'($urandom_range(0, 15));
                    else if (r < 13)
                        code = CODE_OP;
                    else if (r < 15)
                        code = CODE_SYM;
                    else if (r < 17)
                        code = CODE_NONE;
                    else
                        code = 5'($urandom_range(19, 31));
                    row = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
                    send(mk(CMD_LOAD, row, pick_char(), code));
                end
            end
            n = $urandom_range(1, 12);
            repeat (n) begin
                if ($urandom_range(0, 19) == 0)
                    send(mk(CMD_NONE, 4'($urandom), 8'($urandom), 5'($urandom)));
                send(mk(CMD_CHAR, 4'($urandom), pick_char(), 5'($urandom)));
            end
            if ($urandom_range(0, 9) != 0)
                send(mk(CMD_END, 4'($urandom), 8'($urandom), 5'($urandom)));
            quiet = (sent >= QUIET_FROM);
            hold_go = (sent >= HOLD_AT);
        end
        item_valid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/tdl_pkg.sv
hw/rtl/tdl_front.sv
hw/rtl/tdl_back.sv
hw/rtl/tdl_outbuf.sv
hw/rtl/table_driven_lexer_dfa_unit.sv
test/tdl_checker.sv
test/tb_top.sv
